// ===== rtl/tdw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdw_pkg
// Shared types, command codes and the quaternion product term table for the
// trajectory derivative window.
// ----------------------------------------------------------------------------
package tdw_pkg;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [47:0] vel_x;
      logic signed [47:0] vel_y;
      logic signed [47:0] vel_z;
      logic signed [47:0] acc_x;
      logic signed [47:0] acc_y;
      logic signed [47:0] acc_z;
      logic signed [47:0] angvel_x;
      logic signed [47:0] angvel_y;
      logic signed [47:0] angvel_z;
      logic signed [47:0] angacc_x;
      logic signed [47:0] angacc_y;
      logic signed [47:0] angacc_z;
   } rsp_payload_type;

   // request kinds
   localparam logic REQ_POSE  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // scale operand select
   localparam logic [2:0] ASEL_PM  = 3'd0;  // new - middle
   localparam logic [2:0] ASEL_PO  = 3'd1;  // new - older
   localparam logic [2:0] ASEL_ACC = 3'd2;  // new - 2*middle + older
   localparam logic [2:0] ASEL_MO  = 3'd3;  // middle - older
   localparam logic [2:0] ASEL_QD  = 3'd4;  // quaternion product vector part
   localparam logic [2:0] ASEL_WD  = 3'd5;  // w_fwd - w_back

   localparam logic BSEL_IST  = 1'b0;
   localparam logic BSEL_ISTS = 1'b1;

   localparam logic [1:0] SH_12 = 2'd0;
   localparam logic [1:0] SH_13 = 2'd1;
   localparam logic [1:0] SH_23 = 2'd2;

   localparam logic [1:0] GRP_VEL    = 2'd0;
   localparam logic [1:0] GRP_ACC    = 2'd1;
   localparam logic [1:0] GRP_ANGVEL = 2'd2;
   localparam logic [1:0] GRP_ANGACC = 2'd3;

   localparam logic PAIR_OM = 1'b0;  // q1 = older,  q2 = middle
   localparam logic PAIR_MN = 1'b1;  // q1 = middle, q2 = new

   localparam logic CSR_IST  = 1'b0;
   localparam logic CSR_ISTS = 1'b1;

   typedef struct packed {
      logic       load;
      logic       clear_r;
      logic       mac;
      logic [3:0] mac_idx;
      logic       pair;
      logic       scl_start;
      logic [2:0] asel;
      logic       bsel;
      logic [1:0] sh;
      logic [1:0] comp;
      logic [1:0] grp;
      logic       emit;
      logic       win_shift;
      logic       win_clear;
   } dp_cmd_type;

   typedef struct packed {
      logic scl_done;
      logic out_free;
   } dp_status_type;

   // term k of q2*conj(q1): component k[3:2], q2 index k[1:0];
   // returns {negate, q1 index}
   function automatic logic [2:0] quat_term(input logic [3:0] k);
      logic [2:0] t;
      case (k)
         4'd0:    t = 3'b000;
         4'd1:    t = 3'b001;
         4'd2:    t = 3'b010;
         4'd3:    t = 3'b011;
         4'd4:    t = 3'b101;
         4'd5:    t = 3'b000;
         4'd6:    t = 3'b111;
         4'd7:    t = 3'b010;
         4'd8:    t = 3'b110;
         4'd9:    t = 3'b011;
         4'd10:   t = 3'b000;
         4'd11:   t = 3'b101;
         4'd12:   t = 3'b111;
         4'd13:   t = 3'b110;
         4'd14:   t = 3'b001;
         default: t = 3'b000;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tdw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdw_ctrl
// Sequencer: picks the difference scheme per item and steps the datapath
// through its scale and quaternion product operations.
// ----------------------------------------------------------------------------
module tdw_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_flush,
   output logic                    req_stall,
   output tdw_pkg::dp_cmd_type     cmd,
   input  tdw_pkg::dp_status_type  status
);
   import tdw_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RUN    = 3'd1;
   localparam logic [2:0] S_MAC    = 3'd2;
   localparam logic [2:0] S_SSTART = 3'd3;
   localparam logic [2:0] S_SWAIT  = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;

   localparam logic [2:0] M_NONE = 3'd0;
   localparam logic [2:0] M_ZERO = 3'd1;
   localparam logic [2:0] M_FWD  = 3'd2;
   localparam logic [2:0] M_CEN  = 3'd3;
   localparam logic [2:0] M_BWD  = 3'd4;

   localparam logic [1:0] OPK_END = 2'd0;
   localparam logic [1:0] OPK_LIN = 2'd1;
   localparam logic [1:0] OPK_HAV = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [2:0] mode_ff, mode_in;
   logic [2:0] step_ff, step_in;
   logic [3:0] k_ff, k_in;
   logic [1:0] comp_ff, comp_in;
   logic [1:0] fill_ff, fill_in;
   logic       flush_ff, flush_in;

   logic [1:0] op_kind;
   logic [2:0] op_asel;
   logic       op_bsel;
   logic [1:0] op_sh;
   logic [1:0] op_grp;
   logic       op_pair;
   logic       accept;
   logic       emit_needed;

   always_comb begin
      op_kind = OPK_END;
      op_asel = ASEL_PM;
      op_bsel = BSEL_IST;
      op_sh   = SH_12;
      op_grp  = GRP_VEL;
      op_pair = PAIR_OM;
      unique case (mode_ff)
         M_FWD: begin
            unique case (step_ff)
               3'd0: begin
                  op_kind = OPK_LIN;
                  op_asel = ASEL_PM;
               end
               3'd1: begin
                  op_kind = OPK_HAV;
                  op_pair = PAIR_MN;
                  op_grp  = GRP_ANGVEL;
               end
               default: op_kind = OPK_END;
            endcase
         end
         M_BWD: begin
            unique case (step_ff)
               3'd0: begin
                  op_kind = OPK_LIN;
                  op_asel = ASEL_MO;
               end
               3'd1: begin
                  op_kind = OPK_HAV;
                  op_pair = PAIR_OM;
                  op_grp  = GRP_ANGVEL;
               end
               default: op_kind = OPK_END;
            endcase
         end
         M_CEN: begin
            unique case (step_ff)
               3'd0: begin
                  op_kind = OPK_LIN;
                  op_asel = ASEL_PO;
                  op_sh   = SH_13;
               end
               3'd1: begin
                  op_kind = OPK_LIN;
                  op_asel = ASEL_ACC;
                  op_bsel = BSEL_ISTS;
                  op_grp  = GRP_ACC;
               end
               3'd2: begin
                  op_kind = OPK_HAV;
                  op_pair = PAIR_OM;
                  op_grp  = GRP_ANGACC;
               end
               3'd3: begin
                  op_kind = OPK_HAV;
                  op_pair = PAIR_MN;
                  op_grp  = GRP_ANGVEL;
               end
               3'd4: begin
                  op_kind = OPK_LIN;
                  op_asel = ASEL_WD;
                  op_grp  = GRP_ANGACC;
               end
               default: op_kind = OPK_END;
            endcase
         end
         default: op_kind = OPK_END;
      endcase
      if (op_kind == OPK_HAV) begin
         op_asel = ASEL_QD;
         op_bsel = BSEL_IST;
         op_sh   = SH_23;
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && (state_ff == S_IDLE);
   assign emit_needed = (mode_ff != M_NONE);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      comp_in  = comp_ff;
      fill_in  = fill_ff;
      flush_in = flush_ff;

      cmd           = '0;
      cmd.load      = accept;
      cmd.clear_r   = accept;
      cmd.mac_idx   = k_ff;
      cmd.pair      = op_pair;
      cmd.asel      = op_asel;
      cmd.bsel      = op_bsel;
      cmd.sh        = op_sh;
      cmd.comp      = comp_ff;
      cmd.grp       = op_grp;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               flush_in = req_flush;
               step_in  = 3'd0;
               state_in = S_RUN;
               if (!req_flush) begin
                  unique case (fill_ff)
                     2'd0:    mode_in = M_NONE;
                     2'd1:    mode_in = M_FWD;
                     default: mode_in = M_CEN;
                  endcase
               end else begin
                  unique case (fill_ff)
                     2'd0:    mode_in = M_NONE;
                     2'd1:    mode_in = M_ZERO;
                     default: mode_in = M_BWD;
                  endcase
               end
            end
         end
         S_RUN: begin
            comp_in = 2'd0;
            k_in    = 4'd0;
            unique case (op_kind)
               OPK_LIN: state_in = S_SSTART;
               OPK_HAV: state_in = S_MAC;
               default: state_in = S_FIN;
            endcase
         end
         S_MAC: begin
            cmd.mac = 1'b1;
            k_in    = k_ff + 4'd1;
            if (k_ff == 4'd15) begin
               state_in = S_SSTART;
            end
         end
         S_SSTART: begin
            cmd.scl_start = 1'b1;
            state_in      = S_SWAIT;
         end
         S_SWAIT: begin
            if (status.scl_done) begin
               if (comp_ff == 2'd2) begin
                  step_in  = step_ff + 3'd1;
                  state_in = S_RUN;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_SSTART;
               end
            end
         end
         S_FIN: begin
            if (!emit_needed || status.out_free) begin
               cmd.emit      = emit_needed;
               cmd.win_shift = !flush_ff;
               cmd.win_clear = flush_ff;
               if (flush_ff) begin
                  fill_in = 2'd0;
               end else if (fill_ff != 2'd2) begin
                  fill_in = fill_ff + 2'd1;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= M_NONE;
         step_ff  <= 3'd0;
         k_ff     <= 4'd0;
         comp_ff  <= 2'd0;
         fill_ff  <= 2'd0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
         comp_ff  <= comp_in;
         fill_ff  <= fill_in;
         flush_ff <= flush_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tdw_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdw_datapath
// Pose window, slot time registers, quaternion MAC, sequential scale unit
// (50x16 multiplier, three passes, round and saturate) and result register.
// ----------------------------------------------------------------------------
module tdw_datapath (
   input  wire                       clock,
   input  wire                       reset,
   input  tdw_pkg::req_payload_type  req_data,
   input  tdw_pkg::dp_cmd_type       cmd,
   output tdw_pkg::dp_status_type    status,
   input  wire                       csr_valid,
   input  wire                       csr_ready,
   input  wire                       csr_index,
   input  wire [47:0]                csr_data,
   input  wire                       rsp_stall,
   output logic                      rsp_valid,
   output tdw_pkg::rsp_payload_type  rsp_data
);
   import tdw_pkg::*;

   logic        [31:0] ist_ff;
   logic        [47:0] ists_ff;

   logic signed [31:0] new_pos_ff [3];
   logic signed [31:0] mid_pos_ff [3];
   logic signed [31:0] old_pos_ff [3];
   logic signed [15:0] new_quat_ff [4];
   logic signed [15:0] mid_quat_ff [4];
   logic signed [15:0] old_quat_ff [4];

   logic signed [33:0] d_ff [4];

   logic signed [47:0] vel_ff [3];
   logic signed [47:0] acc_ff [3];
   logic signed [47:0] av_ff  [3];
   logic signed [47:0] aa_ff  [3];

   logic        [49:0] mag_ff;
   logic               neg_ff;
   logic        [47:0] b_ff;
   logic        [1:0]  sh_ff;
   logic        [1:0]  grp_ff;
   logic        [1:0]  dst_ff;
   logic        [97:0] macc_ff;
   logic        [1:0]  cnt_ff;
   logic               busy_ff;

   logic               rsp_valid_ff;
   rsp_payload_type    rsp_data_ff;

   // quaternion product term
   logic signed [15:0] q1_sel [4];
   logic signed [15:0] q2_sel [4];
   logic        [2:0]  qterm;
   logic signed [31:0] qprod;
   logic signed [33:0] qterm_val;
   logic signed [33:0] qbase;
   logic        [1:0]  qcomp;

   // scale operand
   logic signed [49:0] pn, pm, po;
   logic signed [49:0] a_val;
   logic        [49:0] a_mag;
   logic        [1:0]  dsel;
   logic        [15:0] b_chunk;
   logic        [65:0] prod;
   logic        [97:0] prod_sh;
   logic        [97:0] rsum;
   logic        [97:0] rshift;
   logic               over;
   logic        [47:0] rmag;
   logic        [47:0] rval;
   logic               round_cyc;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q1_sel[i] = (cmd.pair == PAIR_MN) ? mid_quat_ff[i] : old_quat_ff[i];
         q2_sel[i] = (cmd.pair == PAIR_MN) ? new_quat_ff[i] : mid_quat_ff[i];
      end
   end

   assign qterm     = quat_term(cmd.mac_idx);
   assign qprod     = q2_sel[cmd.mac_idx[1:0]] * q1_sel[qterm[1:0]];
   assign qterm_val = qterm[2] ? -34'(qprod) : 34'(qprod);
   assign qcomp     = cmd.mac_idx[3:2];
   assign qbase     = (cmd.mac_idx[1:0] == 2'd0) ? 34'sd0 : d_ff[qcomp];

   assign pn   = 50'(new_pos_ff[cmd.comp]);
   assign pm   = 50'(mid_pos_ff[cmd.comp]);
   assign po   = 50'(old_pos_ff[cmd.comp]);
   assign dsel = cmd.comp + 2'd1;

   always_comb begin
      case (cmd.asel)
         ASEL_PM:  a_val = pn - pm;
         ASEL_PO:  a_val = pn - po;
         ASEL_ACC: a_val = pn - (pm <<< 1) + po;
         ASEL_MO:  a_val = pm - po;
         ASEL_QD:  a_val = d_ff[0][33] ? -50'(d_ff[dsel]) : 50'(d_ff[dsel]);
         ASEL_WD:  a_val = 50'(av_ff[cmd.comp]) - 50'(aa_ff[cmd.comp]);
         default:  a_val = 50'sd0;
      endcase
   end

   assign a_mag = a_val[49] ? 50'(-a_val) : 50'(a_val);

   always_comb begin
      case (cnt_ff)
         2'd0:    b_chunk = b_ff[15:0];
         2'd1:    b_chunk = b_ff[31:16];
         default: b_chunk = b_ff[47:32];
      endcase
   end

   assign prod = mag_ff * b_chunk;

   always_comb begin
      case (cnt_ff)
         2'd0:    prod_sh = {32'd0, prod};
         2'd1:    prod_sh = {16'd0, prod, 16'd0};
         default: prod_sh = {prod, 32'd0};
      endcase
   end

   always_comb begin
      case (sh_ff)
         SH_12: begin
            rsum   = macc_ff + (98'd1 << 11);
            rshift = rsum >> 12;
         end
         SH_13: begin
            rsum   = macc_ff + (98'd1 << 12);
            rshift = rsum >> 13;
         end
         default: begin
            rsum   = macc_ff + (98'd1 << 22);
            rshift = rsum >> 23;
         end
      endcase
   end

   always_comb begin
      if (neg_ff) begin
         over = (|rshift[97:48]) || (rshift[47] && (|rshift[46:0]));
         rmag = over ? 48'h800000000000 : rshift[47:0];
         rval = -rmag;
      end else begin
         over = |rshift[97:47];
         rmag = over ? 48'h7FFFFFFFFFFF : rshift[47:0];
         rval = rmag;
      end
   end

   assign round_cyc       = busy_ff && (cnt_ff == 2'd3);
   assign status.scl_done = round_cyc;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ist_ff  <= 32'd4096;
         ists_ff <= 48'd4096;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_IST) begin
            ist_ff <= csr_data[31:0];
         end else begin
            ists_ff <= csr_data;
         end
      end
   end

   // pose window
   always_ff @(posedge clock) begin
      if (reset || cmd.win_clear) begin
         for (int i = 0; i < 3; i++) begin
            mid_pos_ff[i] <= '0;
            old_pos_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) begin
            mid_quat_ff[i] <= '0;
            old_quat_ff[i] <= '0;
         end
      end else if (cmd.win_shift) begin
         for (int i = 0; i < 3; i++) begin
            old_pos_ff[i] <= mid_pos_ff[i];
            mid_pos_ff[i] <= new_pos_ff[i];
         end
         for (int i = 0; i < 4; i++) begin
            old_quat_ff[i] <= mid_quat_ff[i];
            mid_quat_ff[i] <= new_quat_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         new_pos_ff[0]  <= req_data.pos_x;
         new_pos_ff[1]  <= req_data.pos_y;
         new_pos_ff[2]  <= req_data.pos_z;
         new_quat_ff[0] <= req_data.quat_w;
         new_quat_ff[1] <= req_data.quat_x;
         new_quat_ff[2] <= req_data.quat_y;
         new_quat_ff[3] <= req_data.quat_z;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac) begin
         d_ff[qcomp] <= qbase + qterm_val;
      end
   end

   // scale unit
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else if (cmd.scl_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 2'd0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scl_start) begin
         mag_ff  <= a_mag;
         neg_ff  <= a_val[49];
         b_ff    <= (cmd.bsel == BSEL_ISTS) ? ists_ff : {16'd0, ist_ff};
         sh_ff   <= cmd.sh;
         grp_ff  <= cmd.grp;
         dst_ff  <= cmd.comp;
         macc_ff <= '0;
      end else if (busy_ff && (cnt_ff != 2'd3)) begin
         macc_ff <= macc_ff + prod_sh;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.clear_r) begin
         for (int i = 0; i < 3; i++) begin
            vel_ff[i] <= '0;
            acc_ff[i] <= '0;
            av_ff[i]  <= '0;
            aa_ff[i]  <= '0;
         end
      end else if (round_cyc) begin
         case (grp_ff)
            GRP_VEL:    vel_ff[dst_ff] <= rval;
            GRP_ACC:    acc_ff[dst_ff] <= rval;
            GRP_ANGVEL: av_ff[dst_ff]  <= rval;
            default:    aa_ff[dst_ff]  <= rval;
         endcase
      end
   end

   // output beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.vel_x    <= vel_ff[0];
         rsp_data_ff.vel_y    <= vel_ff[1];
         rsp_data_ff.vel_z    <= vel_ff[2];
         rsp_data_ff.acc_x    <= acc_ff[0];
         rsp_data_ff.acc_y    <= acc_ff[1];
         rsp_data_ff.acc_z    <= acc_ff[2];
         rsp_data_ff.angvel_x <= av_ff[0];
         rsp_data_ff.angvel_y <= av_ff[1];
         rsp_data_ff.angvel_z <= av_ff[2];
         rsp_data_ff.angacc_x <= aa_ff[0];
         rsp_data_ff.angacc_y <= aa_ff[1];
         rsp_data_ff.angacc_z <= aa_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/trajectory_derivative_window_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trajectory_derivative_window_core
// Finite-difference velocity, acceleration and quaternion rate over a
// three-slot pose window.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: one beat per pose (req_type 0) or end-of-trajectory flush
//     (req_type 1). A pose beat returns the previous slot's derivatives.
//   rsp_*: at most one beat per request, held in an output register.
//   csr_*: slot time registers, index 0 = 1/h, 1 = 1/h^2; write only while
//     idle; csr_ready is always high.
//   req_stall is high while busy. Each scale runs on one 50x16 multiplier
//     (3 passes + round/saturate); each quaternion product on one 16x16
//     MAC. 3 scales per linear group, 16 MACs + 3 scales per rate.
//   The output register holds a beat while rsp_stall is high; the next item
//   is accepted meanwhile and waits at its end until the register frees.
//   Reset: window empty, 1/h and 1/h^2 return to 4096 (1.0), no rsp beat.
// ----------------------------------------------------------------------------
module trajectory_derivative_window_core (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  tdw_pkg::req_payload_type  req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output tdw_pkg::rsp_payload_type  rsp_data,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire                       csr_index,
   input  wire [47:0]                csr_data
);
   import tdw_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   tdw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_flush (req_data.req_type == REQ_FLUSH),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   tdw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== tb/sv/trajectory_derivative_window_checker.sv =====
// ----------------------------------------------------------------------------
// trajectory_derivative_window_checker
// Watches the request, result and register channels of the derivative window
// core, predicts each result beat from its own copy of the window and slot
// time registers, and compares every accepted result beat field by field.
// ----------------------------------------------------------------------------
module trajectory_derivative_window_checker (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  wire                       req_stall,
   input  tdw_pkg::req_payload_type  req_data,
   input  wire                       rsp_valid,
   input  wire                       rsp_stall,
   input  tdw_pkg::rsp_payload_type  rsp_data,
   input  wire                       csr_valid,
   input  wire                       csr_ready,
   input  wire                       csr_index,
   input  wire [47:0]                csr_data,
   output int                        error_count,
   output int                        pending_beats
);
   import tdw_pkg::*;

   logic [31:0] rate;
   logic [47:0] rate_sq;
   int          fill;
   longint      old_pos[3];
   longint      old_quat[4];
   longint      mid_pos[3];
   longint      mid_quat[4];
   rsp_payload_type derivs_q[$];

   string field_name[12] = '{"vel_x", "vel_y", "vel_z", "acc_x", "acc_y", "acc_z",
      "angvel_x", "angvel_y", "angvel_z", "angacc_x", "angacc_y", "angacc_z"};

   initial begin
      error_count = 0;
      pending_beats = 0;
   end

   // exact product, round half away from zero on magnitude, saturate to 48 bits
   function automatic longint scaled(input longint a, input logic [47:0] b,
                                     input int unsigned sh);
      logic [127:0] m;
      logic [127:0] p;
      logic [47:0]  lim;
      bit           neg;
      neg = a < 0;
      m = '0;
      m[63:0] = neg ? -a : a;
      p = m * {80'd0, b};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      if (p > {80'd0, lim}) p = {80'd0, lim};
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic void quat_rate(input longint q1[4], input longint q2[4],
                                     output longint w[3]);
      longint dw, dx, dy, dz;
      dw =  q2[0]*q1[0] + q2[1]*q1[1] + q2[2]*q1[2] + q2[3]*q1[3];
      dx = -q2[0]*q1[1] + q2[1]*q1[0] - q2[2]*q1[3] + q2[3]*q1[2];
      dy = -q2[0]*q1[2] + q2[1]*q1[3] + q2[2]*q1[0] - q2[3]*q1[1];
      dz = -q2[0]*q1[3] - q2[1]*q1[2] + q2[2]*q1[1] + q2[3]*q1[0];
      if (dw < 0) begin
         dx = -dx; dy = -dy; dz = -dz;
      end
      w[0] = scaled(dx, {16'd0, rate}, 23);
      w[1] = scaled(dy, {16'd0, rate}, 23);
      w[2] = scaled(dz, {16'd0, rate}, 23);
   endfunction

   task automatic clear_window();
      fill = 0;
      foreach (old_pos[i]) begin old_pos[i] = 0; mid_pos[i] = 0; end
      foreach (old_quat[i]) begin old_quat[i] = 0; mid_quat[i] = 0; end
   endtask

   task automatic predict_slot(input req_payload_type d);
      longint p[3], q[4], r[12], wa[3], wb[3];
      rsp_payload_type e;
      bit emit;
      emit = 0;
      p[0] = d.pos_x; p[1] = d.pos_y; p[2] = d.pos_z;
      q[0] = d.quat_w; q[1] = d.quat_x; q[2] = d.quat_y; q[3] = d.quat_z;
      foreach (r[i]) r[i] = 0;
      if (d.req_type == REQ_POSE) begin
         if (fill == 0) begin
            fill = 1;
         end else if (fill == 1) begin
            for (int i = 0; i < 3; i++) r[i] = scaled(p[i] - mid_pos[i], {16'd0, rate}, 12);
            quat_rate(mid_quat, q, wb);
            for (int i = 0; i < 3; i++) r[6+i] = wb[i];
            emit = 1;
            fill = 2;
         end else begin
            for (int i = 0; i < 3; i++) begin
               r[i] = scaled(p[i] - old_pos[i], {16'd0, rate}, 13);
               r[3+i] = scaled(p[i] - 2*mid_pos[i] + old_pos[i], rate_sq, 12);
            end
            quat_rate(old_quat, mid_quat, wa);
            quat_rate(mid_quat, q, wb);
            for (int i = 0; i < 3; i++) begin
               r[6+i] = wb[i];
               r[9+i] = scaled(wb[i] - wa[i], {16'd0, rate}, 12);
            end
            emit = 1;
         end
         if (fill == 2) begin
            old_pos = mid_pos;
            old_quat = mid_quat;
         end
         mid_pos = p;
         mid_quat = q;
      end else begin
         if (fill >= 2) begin
            for (int i = 0; i < 3; i++)
               r[i] = scaled(mid_pos[i] - old_pos[i], {16'd0, rate}, 12);
            quat_rate(old_quat, mid_quat, wa);
            for (int i = 0; i < 3; i++) r[6+i] = wa[i];
            emit = 1;
         end else if (fill == 1) begin
            emit = 1;
         end
         clear_window();
      end
      if (emit) begin
         e = {r[0][47:0], r[1][47:0], r[2][47:0], r[3][47:0], r[4][47:0], r[5][47:0],
              r[6][47:0], r[7][47:0], r[8][47:0], r[9][47:0], r[10][47:0], r[11][47:0]};
         derivs_q = {derivs_q, e};
      end
   endtask

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      logic [575:0] got_bits, want_bits;
      if (reset) begin
         rate <= 32'd4096;
         rate_sq <= 48'd4096;
         clear_window();
         derivs_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IST) rate <= csr_data[31:0];
            else rate_sq <= csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (derivs_q.size() == 0) begin
               report("result beat with nothing expected");
            end else begin
               want = derivs_q.pop_front();
               got_bits = rsp_data;
               want_bits = want;
               for (int i = 0; i < 12; i++)
                  if (got_bits[(11-i)*48 +: 48] !== want_bits[(11-i)*48 +: 48])
                     report($sformatf("%s got %h want %h", field_name[i],
                        got_bits[(11-i)*48 +: 48], want_bits[(11-i)*48 +: 48]));
            end
         end
         if (req_valid && !req_stall) predict_slot(req_data);
      end
      pending_beats = derivs_q.size();
   end

endmodule

// ===== tb/sv/trajectory_derivative_window_core_test.sv =====
// ----------------------------------------------------------------------------
// trajectory_derivative_window_core_test
// Drives pose and flush beats into the derivative window core across several
// slot time settings, with random gaps and result stalls; a checker beside
// the core predicts and compares every result beat.
// ----------------------------------------------------------------------------
module trajectory_derivative_window_core_test;
   import tdw_pkg::*;

   logic            clock = 0;
   logic            reset = 1;
   logic            req_valid = 0;
   wire             req_stall;
   req_payload_type req_data = '0;
   wire             rsp_valid;
   logic            rsp_stall = 0;
   rsp_payload_type rsp_data;
   logic            csr_valid = 0;
   wire             csr_ready;
   logic            csr_index = CSR_IST;
   logic [47:0]     csr_data = '0;
   int              error_count;
   int              pending_beats;
   bit              quiet = 0;
   req_payload_type prev_pose = '0;
   int              sent = 0;

   always #6 clock = ~clock;

   trajectory_derivative_window_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   trajectory_derivative_window_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .error_count(error_count), .pending_beats(pending_beats)
   );

   always @(posedge clock)
      rsp_stall <= !quiet && ($urandom_range(99) < 8);

   // valid stays high after the accepting edge; the next beat or settle()
   // decides whether it drops
   task automatic send_beat(input req_payload_type d);
      if (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      quiet = (sent >= 700 && sent < 950);
   endtask

   task automatic pose(input logic signed [31:0] x, y, z,
                       input logic signed [15:0] w, qx, qy, qz);
      req_payload_type d;
      d = {REQ_POSE, x, y, z, w, qx, qy, qz};
      send_beat(d);
   endtask

   task automatic flush();
      req_payload_type d;
      d = {REQ_FLUSH, 32'($urandom), 32'($urandom), 32'($urandom), 64'({$urandom, $urandom})};
      send_beat(d);
   endtask

   task automatic drift_pose();
      req_payload_type d;
      d = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom};
      d.req_type = REQ_POSE;
      if ($urandom_range(3) != 0) begin
         d.pos_x = prev_pose.pos_x + $signed(32'($urandom_range(4095))) - 2048;
         d.pos_y = prev_pose.pos_y + $signed(32'($urandom_range(4095))) - 2048;
         d.pos_z = prev_pose.pos_z + $signed(32'($urandom_range(4095))) - 2048;
         d.quat_w = 16'sd16000 + $signed(16'($urandom_range(767)));
      end
      prev_pose = d;
      send_beat(d);
   endtask

   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // valid stays high after the writing edge; the caller drops it
   task automatic write_reg(input logic idx, input logic [47:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      flush();
      pose(32'sd65536, 0, 0, 16'sd16384, 0, 0, 0);
      flush();
      pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      flush();
      pose(0, 0, 0, 16'sd16384, 0, 0, 0);
      pose(32'sd65536, 32'sd131072, -32'sd65536, 16'sd11585, 16'sd11585, 0, 0);
      pose(32'sd262144, 32'sd65536, 32'sd5, -16'sd16384, 0, 0, 0);
      pose(32'h8000_0000, 32'h7FFF_FFFF, -32'sd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      pose(32'h7FFF_FFFF, 32'h8000_0000, 32'sd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      flush();
      pose(-32'sd1, -32'sd1, -32'sd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      pose(32'sd1, 32'sd1, 32'sd1, 0, 16'sd1, 16'sd1, 16'sd1);
      pose(0, 0, 0, 0, 0, 0, 0);
      flush();
      flush();
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(CSR_IST, 48'd0); write_reg(CSR_ISTS, 48'd0); end
            1: begin
               write_reg(CSR_IST, 48'hFFFF_FFFF);
               write_reg(CSR_ISTS, 48'hFFFF_FFFF_FFFF);
            end
            2: begin write_reg(CSR_IST, 48'd1); write_reg(CSR_ISTS, 48'd1); end
            3: begin write_reg(CSR_IST, 48'd4096); write_reg(CSR_ISTS, 48'd4096); end
            4: begin
               write_reg(CSR_IST, 48'($urandom_range(1 << 20)));
               write_reg(CSR_ISTS, 48'($urandom_range(1 << 28)));
            end
            default: begin
               write_reg(CSR_IST, 48'($urandom));
               write_reg(CSR_ISTS, {16'($urandom), 32'($urandom)});
            end
         endcase
         csr_valid <= 0;
         for (int k = 0; k < 250; ) begin
            int len;
            len = $urandom_range(6);
            for (int j = 0; j < len; j++) begin
               if ($urandom_range(19) == 0) flush();
               else drift_pose();
               k++;
            end
            flush();
            k++;
         end
         settle();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #(12 * 3_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
